// ----- rtl/ubfh_pkg.sv -----
// Shared types, codes and constants of the UART bootloader flash host.
package ubfh_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] status_t;

  // Default parameter and reset values
  localparam int           BLOCK_SIZE_DEF  = 32;
  localparam logic [31:0]  FLASH_BASE_RST  = 32'h0800_0000;
  localparam logic [19:0]  ACK_TIMEOUT_RST = 20'd500000;
  localparam logic [19:0]  WAIT_MAX        = 20'hF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_FLASH_BASE  = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

  // Input item codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FW    = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result status codes
  localparam status_t STAT_OK     = 3'd0;
  localparam status_t STAT_DONE   = 3'd1;
  localparam status_t STAT_ABORT  = 3'd2;
  localparam status_t STAT_REJECT = 3'd3;
  localparam status_t STAT_SKIP   = 3'd4;

  // Protocol phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_SYNC      = 4'd1;
  localparam logic [3:0] PH_ERASE_CMD = 4'd2;
  localparam logic [3:0] PH_ERASE_ALL = 4'd3;
  localparam logic [3:0] PH_READY     = 4'd4;
  localparam logic [3:0] PH_WCMD      = 4'd5;
  localparam logic [3:0] PH_WADDR     = 4'd6;
  localparam logic [3:0] PH_WDATA     = 4'd7;

  // Transmit sequence kinds
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_TX1   = 3'd1;
  localparam logic [2:0] K_TX2   = 3'd2;
  localparam logic [2:0] K_ERASE = 3'd3;
  localparam logic [2:0] K_ADDR  = 3'd4;
  localparam logic [2:0] K_FRAME = 3'd5;

  // Protocol bytes
  localparam byte_t SYNC_BYTE      = 8'h7F;
  localparam byte_t TGT_ACK        = 8'h79;
  localparam byte_t ERASE_CMD      = 8'h44;
  localparam byte_t ERASE_CMD_N    = 8'hBB;
  localparam byte_t WRITE_CMD      = 8'h31;
  localparam byte_t WRITE_CMD_N    = 8'hCE;
  localparam byte_t PAD_BYTE       = 8'hFF;
  localparam byte_t GLOBAL_ERASE   = 8'hFF;
  localparam byte_t GLOBAL_ERASE_X = 8'h00;

endpackage

// ----- rtl/ubfh_buf.sv -----
// Block buffer: one write port, one registered read port.
module ubfh_buf #(
  parameter int BLOCK_SIZE = ubfh_pkg::BLOCK_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(BLOCK_SIZE)-1:0] wr_addr,
  input  ubfh_pkg::byte_t               wr_data,
  input  logic [$clog2(BLOCK_SIZE)-1:0] rd_addr,
  output ubfh_pkg::byte_t               rd_data
);
  import ubfh_pkg::*;

  byte_t mem [BLOCK_SIZE];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/uart_bootloader_flash_host.sv -----
// Top level: UART bootloader host sequencer with block buffer and frame emitter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in_     | in        | in_valid / in_stall  | op, byte_in, end_of_image
//  out_    | out       | out_valid / out_stall| tx_valid, tx_byte, run_last, status
//  cfg_    | in        | cfg_valid / cfg_ready| index, data (flash_base, ack_timeout)
//
// An item is decoded when accepted, then its result beats are emitted; a data frame is
// the fill rounded up to four plus 2 beats, read one buffer byte per cycle while the
// output is free, through one XOR unit. in_stall stays high while the beats of an item
// are being emitted. Output stalls hold the sequencer.
// Reset is synchronous; no clearing pass, the buffer is only read where written.
module uart_bootloader_flash_host #(
  parameter int BLOCK_SIZE = ubfh_pkg::BLOCK_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  ubfh_pkg::byte_t   in_byte_in,
  input  logic              in_end_of_image,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_tx_valid,
  output ubfh_pkg::byte_t   out_tx_byte,
  output logic              out_run_last,
  output ubfh_pkg::status_t out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import ubfh_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_SIZE + 1);
  localparam int AW    = $clog2(BLOCK_SIZE);
  localparam int IDX_W = $clog2(BLOCK_SIZE + 6);
  localparam logic [CNT_W-1:0] BS_CNT = CNT_W'(BLOCK_SIZE);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             st_r, st_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             final_r, final_nxt;
  logic [31:0]      next_addr_r, next_addr_nxt;
  logic [19:0]      wait_r, wait_nxt;
  logic [31:0]      flash_base_r;
  logic [19:0]      timeout_r;
  status_t          pre_r, pre_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  byte_t            cs_r, cs_nxt;
  byte_t            b0_r, b0_nxt;
  byte_t            b1_r, b1_nxt;
  logic [31:0]      addr_sh_r, addr_sh_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_tx_valid_r, out_tx_valid_nxt;
  byte_t            out_tx_byte_r, out_tx_byte_nxt;
  logic             out_run_last_r, out_run_last_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             in_acc, out_free, waiting, adv, adv_to;
  logic [19:0]      wait_inc, limit;
  logic             mem_we;
  byte_t            rd_data;
  logic [IDX_W-1:0] aligned, frame_last, idx_m1, rd_idx;
  byte_t            body_byte;
  logic             body_last;

  ubfh_buf #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_buf (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(in_byte_in),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_data)
  );

  // Read one ahead: the buffer byte for beat idx is fetched while idx is chosen.
  assign rd_idx = idx_nxt - IDX_W'(1);

  assign aligned    = (IDX_W'(fill_r) + IDX_W'(3)) & ~IDX_W'(3);
  assign frame_last = aligned + IDX_W'(1);
  assign idx_m1     = idx_r - IDX_W'(1);

  always_comb begin
    body_byte = PAD_BYTE;
    body_last = 1'b0;
    case (kind_r)
      K_TX1: begin
        body_byte = b0_r;
        body_last = 1'b1;
      end
      K_TX2: begin
        body_byte = (idx_r == '0) ? b0_r : b1_r;
        body_last = (idx_r == IDX_W'(1));
      end
      K_ERASE: begin
        body_byte = (idx_r == IDX_W'(2)) ? GLOBAL_ERASE_X : GLOBAL_ERASE;
        body_last = (idx_r == IDX_W'(2));
      end
      K_ADDR: begin
        body_byte = (idx_r == IDX_W'(4)) ? cs_r : addr_sh_r[31:24];
        body_last = (idx_r == IDX_W'(4));
      end
      K_FRAME: begin
        if (idx_r == '0) begin
          body_byte = 8'(aligned - IDX_W'(1));
        end else if (idx_r == frame_last) begin
          body_byte = cs_r;
        end else if (idx_m1 < IDX_W'(fill_r)) begin
          body_byte = rd_data;
        end else begin
          body_byte = PAD_BYTE;
        end
        body_last = (idx_r == frame_last);
      end
      default: begin
        body_byte = PAD_BYTE;
        body_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    st_nxt           = st_r;
    phase_nxt        = phase_r;
    fill_nxt         = fill_r;
    final_nxt        = final_r;
    next_addr_nxt    = next_addr_r;
    wait_nxt         = wait_r;
    pre_nxt          = pre_r;
    kind_nxt         = kind_r;
    idx_nxt          = idx_r;
    cs_nxt           = cs_r;
    b0_nxt           = b0_r;
    b1_nxt           = b1_r;
    addr_sh_nxt      = addr_sh_r;
    out_valid_nxt    = out_valid_r;
    out_tx_valid_nxt = out_tx_valid_r;
    out_tx_byte_nxt  = out_tx_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_status_nxt   = out_status_r;
    mem_we           = 1'b0;
    adv              = 1'b0;
    adv_to           = 1'b0;

    in_acc   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    wait_inc = (wait_r != WAIT_MAX) ? wait_r + 20'd1 : wait_r;
    limit    = (timeout_r == '0) ? 20'd1 : timeout_r;
    waiting  = phase_r inside {PH_SYNC, PH_ERASE_CMD, PH_ERASE_ALL,
                               PH_WCMD, PH_WADDR, PH_WDATA};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (st_r == ST_IDLE) begin
      if (in_acc) begin
        pre_nxt  = STAT_OK;
        kind_nxt = K_NONE;
        idx_nxt  = '0;
        cs_nxt   = '0;
        case (in_op)
          OP_START: begin
            if (phase_r == PH_IDLE) begin
              next_addr_nxt = flash_base_r;
              fill_nxt      = '0;
              final_nxt     = 1'b0;
              kind_nxt      = K_TX1;
              b0_nxt        = SYNC_BYTE;
              phase_nxt     = PH_SYNC;
              wait_nxt      = '0;
            end else begin
              pre_nxt = STAT_REJECT;
            end
          end
          OP_FW: begin
            if (phase_r == PH_READY && fill_r < BS_CNT) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
              if (fill_nxt >= BS_CNT || in_end_of_image) begin
                final_nxt = in_end_of_image;
                kind_nxt  = K_TX2;
                b0_nxt    = WRITE_CMD;
                b1_nxt    = WRITE_CMD_N;
                phase_nxt = PH_WCMD;
                wait_nxt  = '0;
              end
            end else begin
              pre_nxt = STAT_REJECT;
            end
          end
          OP_RX: begin
            if (waiting && in_byte_in == TGT_ACK) begin
              adv = 1'b1;
            end
          end
          default: begin
            if (waiting) begin
              wait_nxt = wait_inc;
              if (wait_inc >= limit) begin
                adv    = 1'b1;
                adv_to = 1'b1;
              end
            end
          end
        endcase

        if (adv) begin
          case (phase_r)
            PH_SYNC: begin
              if (adv_to) begin
                pre_nxt = STAT_SKIP;
              end
              kind_nxt  = K_TX2;
              b0_nxt    = ERASE_CMD;
              b1_nxt    = ERASE_CMD_N;
              phase_nxt = PH_ERASE_CMD;
              wait_nxt  = '0;
            end
            PH_ERASE_CMD: begin
              if (adv_to) begin
                pre_nxt   = STAT_SKIP;
                phase_nxt = PH_READY;
              end else begin
                kind_nxt  = K_ERASE;
                phase_nxt = PH_ERASE_ALL;
                wait_nxt  = '0;
              end
            end
            PH_ERASE_ALL: begin
              if (adv_to) begin
                pre_nxt = STAT_SKIP;
              end
              phase_nxt = PH_READY;
            end
            PH_WCMD, PH_WADDR, PH_WDATA: begin
              if (adv_to) begin
                pre_nxt   = STAT_ABORT;
                phase_nxt = PH_IDLE;
              end else if (phase_r == PH_WCMD) begin
                kind_nxt      = K_ADDR;
                addr_sh_nxt   = next_addr_r;
                next_addr_nxt = next_addr_r + 32'(BLOCK_SIZE);
                phase_nxt     = PH_WADDR;
                wait_nxt      = '0;
              end else if (phase_r == PH_WADDR) begin
                kind_nxt  = K_FRAME;
                phase_nxt = PH_WDATA;
                wait_nxt  = '0;
              end else begin
                fill_nxt = '0;
                if (final_r) begin
                  pre_nxt   = STAT_DONE;
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt = PH_READY;
                end
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end

        if (pre_nxt != STAT_OK || kind_nxt != K_NONE) begin
          st_nxt = ST_EMIT;
        end
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b1;
      if (pre_r != STAT_OK) begin
        // status-only beat goes ahead of any transmit beats
        out_tx_valid_nxt = 1'b0;
        out_tx_byte_nxt  = '0;
        out_status_nxt   = pre_r;
        out_run_last_nxt = (kind_r == K_NONE);
        pre_nxt          = STAT_OK;
        if (kind_r == K_NONE) begin
          st_nxt = ST_IDLE;
        end
      end else begin
        out_tx_valid_nxt = 1'b1;
        out_tx_byte_nxt  = body_byte;
        out_status_nxt   = STAT_OK;
        out_run_last_nxt = body_last;
        cs_nxt           = cs_r ^ body_byte;
        idx_nxt          = idx_r + IDX_W'(1);
        if (kind_r == K_ADDR) begin
          addr_sh_nxt = {addr_sh_r[23:0], 8'h00};
        end
        if (body_last) begin
          st_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      phase_r      <= PH_IDLE;
      fill_r       <= '0;
      final_r      <= 1'b0;
      next_addr_r  <= '0;
      wait_r       <= '0;
      pre_r        <= STAT_OK;
      kind_r       <= K_NONE;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      flash_base_r <= FLASH_BASE_RST;
      timeout_r    <= ACK_TIMEOUT_RST;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      final_r     <= final_nxt;
      next_addr_r <= next_addr_nxt;
      wait_r      <= wait_nxt;
      pre_r       <= pre_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLASH_BASE:  flash_base_r <= cfg_data;
          CFG_ACK_TIMEOUT: timeout_r    <= cfg_data[19:0];
          default: begin
            timeout_r <= timeout_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cs_r           <= cs_nxt;
    b0_r           <= b0_nxt;
    b1_r           <= b1_nxt;
    addr_sh_r      <= addr_sh_nxt;
    out_tx_valid_r <= out_tx_valid_nxt;
    out_tx_byte_r  <= out_tx_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign in_stall     = (st_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_tx_valid = out_tx_valid_r;
  assign out_tx_byte  = out_tx_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_status   = out_status_r;

  a_ready_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY) |-> (fill_r < BS_CNT))
    else $error("block buffer full while waiting for firmware");

  a_frame_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && kind_r == K_FRAME) |-> (fill_r != '0))
    else $error("data frame emitted from an empty block");

  a_emit_work: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> (pre_r != STAT_OK || kind_r != K_NONE))
    else $error("sequencer busy with nothing to send");

  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && st_nxt == ST_IDLE) |=> (out_valid_r && out_run_last_r))
    else $error("sequence ended without a run_last beat");

endmodule
